@@ hdl/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the depth-first maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    localparam int CFG_W  = 7;
    localparam int XY_W   = 6;
    localparam int DONE_W = 13;
    localparam int RND_W  = 15;

    // rnd mod 3 by reciprocal: q = (rnd * RECIP3) >> RECIP3_SHIFT
    localparam int          RECIP3_W     = 16;
    localparam int          PROD_W       = RND_W + RECIP3_W;
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    typedef enum logic [1:0] {
        EV_CARVED    = 2'd0,
        EV_BACK      = 2'd1,
        EV_FINISHED  = 2'd2,
        EV_RESTARTED = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP,
        S_MID,
        S_DOWN,
        S_EMIT
    } state_t;

    typedef struct packed {
        event_t              kind;
        logic [XY_W-1:0]     from_x;
        logic [XY_W-1:0]     from_y;
        logic [XY_W-1:0]     to_x;
        logic [XY_W-1:0]     to_y;
        dir_t                wall;
        logic [DONE_W-1:0]   done;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/dmc_ram.sv @@
// ----------------------------------------------------------------------------
// dmc_ram
// Simple dual-port synchronous memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/dfs_maze_carver_top.sv @@
// ----------------------------------------------------------------------------
// dfs_maze_carver_top
// Randomized depth-first maze carver, one carving step per request.
//
// Requests arrive on in_valid/in_ready with random_value and restart; each
// request yields exactly one result on out_valid/out_ready (event_kind,
// from/to cell, wall_direction, cells_done). Grid size is set through the
// write port (cfg_write, cfg_index, cfg_data); the user must write it only
// while the block is idle, which the block itself does not enforce. The
// visited map is a memory of one row per word; the cell stack is a second
// memory with the top entry held in registers. A normal step runs through
// the accept, three reads of the visited memory (row above, own row, row
// below) and the write-back, in S_IDLE, S_UP, S_MID and S_DOWN. A step on
// a finished maze registers its result at the accepting edge. A restart
// clears the visited memory one row per cycle, all MAX_HEIGHT rows, then
// delivers its result from S_EMIT. After reset the same clearing pass runs
// with in_ready low. One result register sits at the output; when the
// receiver stalls with a result still waiting, the next step completes into
// a hold register and the block waits there until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_maze_carver_top
    import dmc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [RND_W-1:0]  random_value,
    input  wire logic              restart,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [1:0]        event_kind,
    output      logic [XY_W-1:0]   from_x,
    output      logic [XY_W-1:0]   from_y,
    output      logic [XY_W-1:0]   to_x,
    output      logic [XY_W-1:0]   to_y,
    output      logic [1:0]        wall_direction,
    output      logic [DONE_W-1:0] cells_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int SW    = $clog2(CELLS);
    localparam int AW    = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int EW    = CW + RW;

    state_t                state_reg, state_next;
    logic [RW-1:0]         clr_row_reg, clr_row_next;
    logic                  pend_reg, pend_next;
    logic [CFG_W-1:0]      width_reg, height_reg;
    logic [CW-1:0]         top_x_reg, top_x_next;
    logic [RW-1:0]         top_y_reg, top_y_next;
    logic [AW-1:0]         depth_reg, depth_next;
    logic [AW-1:0]         total_reg, total_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [1:0]            rmod3_reg, rmod3_next;
    logic [MAX_WIDTH-1:0]  up_row_reg, up_row_next;
    logic [MAX_WIDTH-1:0]  mid_row_reg, mid_row_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  vis_we, vis_re;
    logic [RW-1:0]         vis_waddr, vis_raddr;
    logic [MAX_WIDTH-1:0]  vis_wdata, vis_rdata;
    logic                  stk_we, stk_re;
    logic [SW-1:0]         stk_waddr, stk_raddr;
    logic [EW-1:0]         stk_wdata, stk_rdata;

    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [AW-1:0]         area;
    logic                  has_top, finished, out_free;
    logic [CW-1:0]         fx;
    logic [RW-1:0]         fy;
    logic [CW:0]           x_ext, w_ext;
    logic [RW:0]           y_ext, h_ext;
    logic                  ok_up, ok_right, ok_down, ok_left;
    logic [CW-1:0]         x_right, x_left;
    logic [3:0]            free;
    logic [2:0]            n_free;
    logic [1:0]            rsel;
    dir_t                  pick;
    logic [CW-1:0]         tx;
    logic [RW-1:0]         ty;
    logic [MAX_WIDTH-1:0]  new_row;
    logic [PROD_W-1:0]     prod;
    logic [RND_W-1:0]      quot;

    dmc_ram #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    dmc_ram #(
        .DEPTH (CELLS),
        .WIDTH (EW)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    assign area     = AW'(AW'(w_eff) * AW'(h_eff));
    assign has_top  = (depth_reg != '0);
    assign fx       = has_top ? top_x_reg : '0;
    assign fy       = has_top ? top_y_reg : '0;
    assign finished = (total_reg >= area) || !has_top;
    assign out_free = !out_valid_reg || out_ready;

    assign x_ext = {1'b0, top_x_reg};
    assign y_ext = {1'b0, top_y_reg};
    assign w_ext = (CW + 1)'(w_eff);
    assign h_ext = (RW + 1)'(h_eff);

    assign ok_up    = (y_ext != '0) && (x_ext < w_ext) && ((y_ext - 1'b1) < h_ext);
    assign ok_right = ((x_ext + 1'b1) < w_ext) && (y_ext < h_ext);
    assign ok_down  = (x_ext < w_ext) && ((y_ext + 1'b1) < h_ext);
    assign ok_left  = (x_ext != '0) && ((x_ext - 1'b1) < w_ext) && (y_ext < h_ext);

    assign x_right = ok_right ? CW'(x_ext + 1'b1) : top_x_reg;
    assign x_left  = ok_left  ? CW'(x_ext - 1'b1) : top_x_reg;

    assign free[DIR_UP]    = ok_up    && !up_row_reg[top_x_reg];
    assign free[DIR_RIGHT] = ok_right && !mid_row_reg[x_right];
    assign free[DIR_DOWN]  = ok_down  && !vis_rdata[top_x_reg];
    assign free[DIR_LEFT]  = ok_left  && !mid_row_reg[x_left];
    assign n_free          = 3'($countones(free));

    assign prod = PROD_W'(rnd_reg) * PROD_W'(RECIP3);
    assign quot = RND_W'(prod >> RECIP3_SHIFT);

    always_comb
    begin
        case (n_free)
            3'd2:    rsel = {1'b0, rnd_reg[0]};
            3'd3:    rsel = rmod3_reg;
            3'd4:    rsel = rnd_reg[1:0];
            default: rsel = 2'd0;
        endcase
    end

    always_comb
    begin
        logic [1:0] cnt;
        logic       found;
        cnt   = 2'd0;
        found = 1'b0;
        pick  = DIR_UP;
        for (int d = 0; d < 4; d++)
        begin
            if (free[d])
            begin
                if (!found && cnt == rsel)
                begin
                    pick  = dir_t'(2'(d));
                    found = 1'b1;
                end
                cnt = cnt + 2'd1;
            end
        end
    end

    always_comb
    begin
        case (pick)
            DIR_UP:
            begin
                tx      = top_x_reg;
                ty      = RW'(y_ext - 1'b1);
                new_row = up_row_reg | (MAX_WIDTH'(1) << top_x_reg);
            end
            DIR_RIGHT:
            begin
                tx      = x_right;
                ty      = top_y_reg;
                new_row = mid_row_reg | (MAX_WIDTH'(1) << x_right);
            end
            DIR_DOWN:
            begin
                tx      = top_x_reg;
                ty      = RW'(y_ext + 1'b1);
                new_row = vis_rdata | (MAX_WIDTH'(1) << top_x_reg);
            end
            default:
            begin
                tx      = x_left;
                ty      = top_y_reg;
                new_row = mid_row_reg | (MAX_WIDTH'(1) << x_left);
            end
        endcase
    end

    always_comb
    begin
        result_t res_new;
        logic    emit;
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        pend_next      = pend_reg;
        top_x_next     = top_x_reg;
        top_y_next     = top_y_reg;
        depth_next     = depth_reg;
        total_next     = total_reg;
        rnd_next       = rnd_reg;
        rmod3_next     = rmod3_reg;
        up_row_next    = up_row_reg;
        mid_row_next   = mid_row_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        vis_we         = 1'b0;
        vis_waddr      = clr_row_reg;
        vis_wdata      = '0;
        vis_re         = 1'b0;
        vis_raddr      = top_y_reg;
        stk_we         = 1'b0;
        stk_waddr      = SW'(depth_reg - 1'b1);
        stk_wdata      = {top_y_reg, top_x_reg};
        stk_re         = 1'b0;
        stk_raddr      = SW'(depth_reg - 2'd2);
        emit           = 1'b0;
        res_new        = '{kind: EV_FINISHED, from_x: XY_W'(fx), from_y: XY_W'(fy),
                           to_x: '0, to_y: '0, wall: DIR_UP,
                           done: DONE_W'(total_reg)};

        case (state_reg)
            S_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_wdata = (clr_row_reg == '0) ? MAX_WIDTH'(1) : '0;
                if (clr_row_reg == RW'(MAX_HEIGHT - 1))
                begin
                    state_next = pend_reg ? S_EMIT : S_IDLE;
                    pend_next  = 1'b0;
                end
                else
                begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rnd_next = random_value;
                    if (restart)
                    begin
                        res_next     = '{kind: EV_RESTARTED, from_x: XY_W'(fx),
                                         from_y: XY_W'(fy), to_x: '0, to_y: '0,
                                         wall: DIR_UP, done: DONE_W'(1)};
                        pend_next    = 1'b1;
                        clr_row_next = '0;
                        depth_next   = AW'(1);
                        total_next   = AW'(1);
                        top_x_next   = '0;
                        top_y_next   = '0;
                        state_next   = S_CLEAR;
                    end
                    else if (finished)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        vis_re     = 1'b1;
                        vis_raddr  = (top_y_reg != '0) ? RW'(y_ext - 1'b1) : top_y_reg;
                        stk_re     = (depth_reg >= AW'(2));
                        state_next = S_UP;
                    end
                end
            end
            S_UP:
            begin
                rmod3_next  = 2'(rnd_reg - quot - RND_W'(quot << 1));
                up_row_next = vis_rdata;
                vis_re      = 1'b1;
                vis_raddr   = top_y_reg;
                state_next  = S_MID;
            end
            S_MID:
            begin
                mid_row_next = vis_rdata;
                vis_re       = 1'b1;
                vis_raddr    = ((y_ext + 1'b1) < (RW + 1)'(MAX_HEIGHT))
                             ? RW'(y_ext + 1'b1) : top_y_reg;
                state_next   = S_DOWN;
            end
            S_DOWN:
            begin
                emit = 1'b1;
                if (n_free == 3'd0)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg >= AW'(2))
                    begin
                        {top_y_next, top_x_next} = stk_rdata;
                    end
                    res_new.kind = EV_BACK;
                end
                else
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = ty;
                    vis_wdata  = new_row;
                    total_next = total_reg + 1'b1;
                    if (int'(depth_reg) < CELLS)
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        top_x_next = tx;
                        top_y_next = ty;
                    end
                    res_new.kind = EV_CARVED;
                    res_new.to_x = XY_W'(tx);
                    res_new.to_y = XY_W'(ty);
                    res_new.wall = pick;
                    res_new.done = DONE_W'(total_reg + 1'b1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            if (out_free)
            begin
                out_next       = res_new;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res_new;
                state_next = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_row_reg   <= '0;
            pend_reg      <= 1'b0;
            top_x_reg     <= '0;
            top_y_reg     <= '0;
            depth_reg     <= AW'(1);
            total_reg     <= AW'(1);
            out_valid_reg <= 1'b0;
            width_reg     <= CFG_W'(64);
            height_reg    <= CFG_W'(64);
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            pend_reg      <= pend_next;
            top_x_reg     <= top_x_next;
            top_y_reg     <= top_y_next;
            depth_reg     <= depth_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next;
        rmod3_reg   <= rmod3_next;
        up_row_reg  <= up_row_next;
        mid_row_reg <= mid_row_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.kind;
    assign from_x         = out_reg.from_x;
    assign from_y         = out_reg.from_y;
    assign to_x           = out_reg.to_x;
    assign to_y           = out_reg.to_y;
    assign wall_direction = out_reg.wall;
    assign cells_done     = out_reg.done;

endmodule

`default_nettype wire

@@ hdl/dmc_checker.sv @@
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the maze carver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_checker
    import dmc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              restart,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        event_kind,
    input wire logic [XY_W-1:0]   from_x,
    input wire logic [XY_W-1:0]   from_y,
    input wire logic [XY_W-1:0]   to_x,
    input wire logic [XY_W-1:0]   to_y,
    input wire logic [1:0]        wall_direction,
    input wire logic [DONE_W-1:0] cells_done
);

    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> !in_ready)
        else $error("request accepted while the map is being cleared");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({event_kind, from_x, from_y,
            to_x, to_y, wall_direction, cells_done}))
        else $error("stalled result changed");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_CARVED |->
            to_x == '0 && to_y == '0 && wall_direction == DIR_UP)
        else $error("target fields set on a non-carve result");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_RESTARTED |-> cells_done == DONE_W'(1))
        else $error("restart result with wrong cell count");

    a_carve_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_CARVED |->
            (wall_direction == DIR_UP    && to_x == from_x && to_y == from_y - 6'd1) ||
            (wall_direction == DIR_RIGHT && to_y == from_y && to_x == from_x + 6'd1) ||
            (wall_direction == DIR_DOWN  && to_x == from_x && to_y == from_y + 6'd1) ||
            (wall_direction == DIR_LEFT  && to_y == from_y && to_x == from_x - 6'd1))
        else $error("carved cell not adjacent across the reported wall");

endmodule

bind dfs_maze_carver_top dmc_checker u_dmc_checker (.*);

`default_nettype wire

@@ sim/tb_dfs_maze_carver_top.sv @@
// ----------------------------------------------------------------------------
// tb_dfs_maze_carver_top
// Self-checking bench for the depth-first maze carver.
//
// A directed table first covers the first carve after reset, restart, the
// one-cell grid, over-range and zero sizes, backtracking, and an emptied
// stack after a size change. Random phases follow on mostly small grids so
// that mazes run to completion. Restarts are frequent once a maze is done.
// Each phase runs under one of four idle patterns on either handshake, and one
// phase holds the output off long enough to back up the input. Every result
// is checked against the table on typed rows, else an in-bench carver model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dfs_maze_carver_top
    import dmc_pkg::*;
();

    localparam int GRID_MAX      = 64;
    localparam int CELLS         = GRID_MAX * GRID_MAX;
    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;
    localparam int DIR_ROWS      = 31;

    typedef enum logic {
        ROW_STEP,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        PACE_NONE,
        PACE_SEND,
        PACE_RECV,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        row_kind_t         kind;
        reg_index_t        reg_sel;
        logic [CFG_W-1:0]  reg_val;
        logic [RND_W-1:0]  rnd;
        logic              restart;
        logic              typed;
        result_t           want;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0000, 1'b0, 1'b1,
          '{EV_CARVED, 6'd0, 6'd0, 6'd1, 6'd0, DIR_RIGHT, 13'd2}},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h7FFF, 1'b1, 1'b1,
          '{EV_RESTARTED, 6'd1, 6'd0, 6'd0, 6'd0, DIR_UP, 13'd1}},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h7FFF, 1'b0, 1'b1,
          '{EV_CARVED, 6'd0, 6'd0, 6'd0, 6'd1, DIR_DOWN, 13'd2}},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0001, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h4000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0002, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_WIDTH, 7'd0, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd0, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h5555, 1'b1, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h2AAA, 1'b0, 1'b1,
          '{EV_FINISHED, 6'd0, 6'd0, 6'd0, 6'd0, DIR_UP, 13'd1}},
        '{ROW_CFG, REG_WIDTH, 7'd1, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd2, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h1234, 1'b1, 1'b1,
          '{EV_RESTARTED, 6'd0, 6'd0, 6'd0, 6'd0, DIR_UP, 13'd1}},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0003, 1'b0, 1'b1,
          '{EV_CARVED, 6'd0, 6'd0, 6'd0, 6'd1, DIR_DOWN, 13'd2}},
        '{ROW_CFG, REG_WIDTH, 7'd4, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd1, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0100, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0200, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0300, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_WIDTH, 7'd1, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd5, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0010, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0020, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0030, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0040, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h0050, 1'b1, 1'b1,
          '{EV_RESTARTED, 6'd0, 6'd0, 6'd0, 6'd0, DIR_UP, 13'd1}},
        '{ROW_CFG, REG_WIDTH, 7'd127, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd127, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_STEP, REG_WIDTH, 7'd0, 15'h6000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_WIDTH, 7'd64, 15'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT, 7'd64, 15'h0000, 1'b0, 1'b0, NO_RESULT}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [RND_W-1:0]  random_value;
    logic              restart;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        event_kind;
    logic [XY_W-1:0]   from_x;
    logic [XY_W-1:0]   from_y;
    logic [XY_W-1:0]   to_x;
    logic [XY_W-1:0]   to_y;
    logic [1:0]        wall_direction;
    logic [DONE_W-1:0] cells_done;

    bit                visited [CELLS];
    logic [XY_W-1:0]   trail_x [CELLS];
    logic [XY_W-1:0]   trail_y [CELLS];
    int unsigned       trail_depth;
    int unsigned       carved_total;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    result_t           pending_results [$];
    int unsigned       mismatches;
    int unsigned       cycle_count;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       hold_requests;
    int unsigned       holds_served;

    dfs_maze_carver_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .random_value   (random_value),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .from_x         (from_x),
        .from_y         (from_y),
        .to_x           (to_x),
        .to_y           (to_y),
        .wall_direction (wall_direction),
        .cells_done     (cells_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int grid_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return int'(v);
    endfunction

    function automatic void clear_maze();
        for (int i = 0; i < CELLS; i++)
            visited[i] = 1'b0;
        visited[0]   = 1'b1;
        trail_x[0]   = '0;
        trail_y[0]   = '0;
        trail_depth  = 1;
        carved_total = 1;
    endfunction

    function automatic bit maze_closed();
        return carved_total >= grid_dim(width_reg) * grid_dim(height_reg) || trail_depth == 0;
    endfunction

    function automatic result_t carve_step(input logic [RND_W-1:0] rnd, input logic rst);
        result_t r;
        int      w;
        int      h;
        int      fx;
        int      fy;
        int      nx;
        int      ny;
        int      n;
        int      pick;
        dir_t    d;
        dir_t    open_dir [4];
        int      open_x [4];
        int      open_y [4];
        r = '0;
        w = grid_dim(width_reg);
        h = grid_dim(height_reg);
        if (trail_depth > 0)
        begin
            r.from_x = trail_x[trail_depth - 1];
            r.from_y = trail_y[trail_depth - 1];
        end
        if (rst)
        begin
            clear_maze();
            r.kind = EV_RESTARTED;
            r.done = DONE_W'(carved_total);
            return r;
        end
        if (carved_total >= w * h || trail_depth == 0)
        begin
            r.kind = EV_FINISHED;
            r.done = DONE_W'(carved_total);
            return r;
        end
        fx = int'(r.from_x);
        fy = int'(r.from_y);
        n  = 0;
        for (int k = 0; k < 4; k++)
        begin
            d  = dir_t'(k);
            nx = fx;
            ny = fy;
            case (d)
                DIR_UP:    ny = fy - 1;
                DIR_RIGHT: nx = fx + 1;
                DIR_DOWN:  ny = fy + 1;
                default:   nx = fx - 1;
            endcase
            if (nx >= 0 && ny >= 0 && nx < w && ny < h && !visited[ny * GRID_MAX + nx])
            begin
                open_dir[n] = d;
                open_x[n]   = nx;
                open_y[n]   = ny;
                n++;
            end
        end
        if (n == 0)
        begin
            trail_depth--;
            r.kind = EV_BACK;
            r.done = DONE_W'(carved_total);
            return r;
        end
        pick = int'(rnd) % n;
        visited[open_y[pick] * GRID_MAX + open_x[pick]] = 1'b1;
        carved_total++;
        if (trail_depth < CELLS)
        begin
            trail_x[trail_depth] = XY_W'(open_x[pick]);
            trail_y[trail_depth] = XY_W'(open_y[pick]);
            trail_depth++;
        end
        r.kind = EV_CARVED;
        r.to_x = XY_W'(open_x[pick]);
        r.to_y = XY_W'(open_y[pick]);
        r.wall = open_dir[pick];
        r.done = DONE_W'(carved_total);
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("kind %0d from (%0d,%0d) to (%0d,%0d) wall %0d done %0d",
                         r.kind, r.from_x, r.from_y, r.to_x, r.to_y, r.wall, r.done);
    endfunction

    task automatic send_request(input logic [RND_W-1:0] rnd, input logic rst,
                                input logic typed, input result_t want);
        result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        random_value = rnd;
        restart      = rst;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predicted = carve_step(rnd, rst);
        pending_results = {pending_results, typed ? want : predicted};
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == REG_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                out_ready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                holds_served++;
            end
            out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            got = '{event_t'(event_kind), from_x, from_y, to_x, to_y,
                    dir_t'(wall_direction), cells_done};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: %s", fmt_result(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.from_x !== want.from_x ||
                    got.from_y !== want.from_y || got.to_x !== want.to_x ||
                    got.to_y !== want.to_y || got.wall !== want.wall ||
                    got.done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected %s, got %s",
                                 fmt_result(want), fmt_result(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] pw;
        logic [CFG_W-1:0] ph;
        logic             rst_pick;
        pace_t            pace;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        random_value   = '0;
        restart        = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        holds_served   = 0;
        width_reg      = CFG_W'(GRID_MAX);
        height_reg     = CFG_W'(GRID_MAX);
        clear_maze();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_CFG)
                write_reg(DIR_TABLE[i].reg_sel, DIR_TABLE[i].reg_val);
            else
                send_request(DIR_TABLE[i].rnd, DIR_TABLE[i].restart,
                             DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 6)
                0:
                begin
                    pw = CFG_W'($urandom_range(1, 8));
                    ph = CFG_W'($urandom_range(1, 8));
                end
                1:
                begin
                    pw = '0;
                    ph = CFG_W'($urandom_range(2, 6));
                end
                2:
                begin
                    pw = CFG_W'($urandom_range(65, 127));
                    ph = CFG_W'($urandom_range(1, 2));
                end
                3:
                begin
                    pw = CFG_W'($urandom_range(2, 12));
                    ph = CFG_W'($urandom_range(2, 12));
                end
                4:
                begin
                    pw = CFG_W'(1);
                    ph = CFG_W'($urandom_range(0, 16));
                end
                default:
                begin
                    pw = (p == 5) ? CFG_W'(GRID_MAX) : '1;
                    ph = pw;
                end
            endcase
            write_reg(REG_WIDTH, pw);
            write_reg(REG_HEIGHT, ph);

            pace = pace_t'(p % 4);
            case (pace)
                PACE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                PACE_SEND:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                PACE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            if (p == 2)
                hold_requests++;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (maze_closed())
                    rst_pick = ($urandom_range(0, 3) == 0);
                else
                    rst_pick = ($urandom_range(0, 39) == 0);
                send_request(RND_W'($urandom_range(0, 32767)), rst_pick, 1'b0, NO_RESULT);
            end
        end

        @(negedge clk);
        in_valid       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/dfs_maze_carver_top.sv
hdl/dmc_checker.sv
sim/tb_dfs_maze_carver_top.sv
